// ===== src/h264fua_pkg.sv =====
// Shared types and constants for the H.264 RTP FU-A packetizer.
`default_nettype none

package h264fua_pkg;

   // Limits and field widths
   localparam int MAX_NAL_BYTES = 1048575;
   localparam int SIZE_W        = 20;
   localparam int PAY_W         = 16;
   localparam int SEQ_W         = 16;
   localparam int STAMP_W       = 32;

   // NAL header bits and FU-A codes
   localparam logic [7:0] NRI_MASK  = 8'h60;
   localparam logic [7:0] TYPE_MASK = 8'h1F;
   localparam logic [7:0] S_BIT     = 8'h80;
   localparam logic [7:0] E_BIT     = 8'h40;
   localparam logic [4:0] FU_A_TYPE = 5'd28;
   localparam logic [4:0] TYPE_SPS  = 5'd7;
   localparam logic [4:0] TYPE_PPS  = 5'd8;

   // Register reset values: 1400 byte payload, 90 kHz clock at 25 fps
   localparam logic [PAY_W-1:0]   MAX_PAYLOAD_RST = 16'd1400;
   localparam logic [STAMP_W-1:0] STAMP_STEP_RST  = STAMP_W'(90000 / 25);

   // Register indexes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STAMP_STEP  = 4'd1;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int MAX_PUSH    = 3;

   // One result byte with its packet marks
   typedef struct packed {
      logic               last_of_item;
      logic [STAMP_W-1:0] time_stamp;
      logic [SEQ_W-1:0]   seq_number;
      logic               packet_end;
      logic               packet_start;
      logic [7:0]         out_byte;
   } rsp_type;

   // Up to three results written in one cycle
   typedef struct packed {
      logic [1:0]               push_count;
      rsp_type [MAX_PUSH-1:0]   entry;
   } push_type;

endpackage

`default_nettype wire

// ===== src/h264fua_res_queue.sv =====
// Four-entry result queue: takes up to three results a cycle, gives one.
`default_nettype none

module h264fua_res_queue
   import h264fua_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          room,
   output logic          head_valid,
   output rsp_type       head,
   input  wire logic     head_ready
);

   rsp_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               pop;
   logic [QPTR_W:0]    count_after_pop;

   // Head of queue
   assign head_valid      = (count_ff != '0);
   assign head            = mem_ff[rd_ptr_ff];
   assign pop             = head_valid & head_ready;
   assign count_after_pop = count_ff - (QPTR_W+1)'(pop);
   // Room for a full three-result request after this cycle's pop
   assign room            = (count_after_pop <= (QPTR_W+1)'(QUEUE_DEPTH - MAX_PUSH));

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.push_count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_after_pop + (QPTR_W+1)'(push.push_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, written at consecutive slots
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PUSH; i++) begin
         if (i < int'(push.push_count)) begin
            mem_ff[wr_ptr_ff + QPTR_W'(i)] <= push.entry[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/h264_rtp_fua_packetizer_core.sv =====
// A request waits in the input register until the result queue has room, then it is
// packetized; its results are written into the result queue and offered on rsp_tvalid.
// One NAL byte per cycle while the queue has room; the first data byte of each FU-A
// fragment yields three results (indicator, FU header, data), so the four-entry result
// queue holds the input at each fragment start until it has room again.
// Reset clears sequence, timestamp and fragment state; registers return to 1400 / 3600.
`default_nettype none

module h264_rtp_fua_packetizer_core
   import h264fua_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request: [7:0] nal_byte, [27:8] nal_size, [31:28] zero
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [31:0]          req_tdata,
   input  wire logic                 req_tuser,   // nal_first
   // result: [7:0] out_byte, [23:8] seq_number, [55:24] time_stamp,
   //         [56] last_of_item, [63:57] zero
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [63:0]               rsp_tdata,
   output logic                      rsp_tuser,   // packet_start
   output logic                      rsp_tlast,   // packet_end
   // register writes
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data
);

   // Configuration
   logic [PAY_W-1:0]   max_payload_ff;
   logic [STAMP_W-1:0] stamp_step_ff;

   // Input register
   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               in_first_ff;
   logic [SIZE_W-1:0]  in_size_ff;

   // Packetizer state
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [7:0]         header_ff, header_in;
   logic [SIZE_W-1:0]  bytes_left_ff, bytes_left_in;
   logic [PAY_W-1:0]   fill_ff, fill_in;
   logic               fragmenting_ff, fragmenting_in;
   logic               first_frag_ff, first_frag_in;

   // Working values
   logic               req_fire;
   logic               room;
   logic               proc_go;
   logic [PAY_W-1:0]   lim;
   logic [SIZE_W-1:0]  size_sat;
   logic [SIZE_W:0]    rem;
   logic [SIZE_W:0]    len_min;
   logic [SIZE_W:0]    frag_len;
   logic [PAY_W:0]     fill_next;
   logic               frag_ends;
   logic               frag_last;
   logic [STAMP_W-1:0] stamp_sum;
   logic               abandon;
   logic [SEQ_W-1:0]   seq_mid;
   logic               hdr_keeps_stamp;
   logic               new_keeps_stamp;
   logic [7:0]         fu_indicator;
   logic [7:0]         fu_header;
   push_type           push;
   rsp_type            head;

   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RST;
         stamp_step_ff  <= STAMP_STEP_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_PAYLOAD: max_payload_ff <= csr_data[PAY_W-1:0];
            CSR_STAMP_STEP:  stamp_step_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Input register: refilled when empty or when its request is processed
   assign proc_go    = in_valid_ff & room;
   assign req_tready = ~in_valid_ff | proc_go;
   assign req_fire   = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_fire | (in_valid_ff & ~proc_go);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff  <= req_tdata[7:0];
         in_first_ff <= req_tuser;
         in_size_ff  <= req_tdata[27:8];
      end
   end

   // Fragment sizing for the current byte
   always_comb begin
      lim      = (max_payload_ff == '0) ? PAY_W'(1) : max_payload_ff;
      size_sat = (in_size_ff == '0) ? SIZE_W'(1) : in_size_ff;
      if (int'(size_sat) > MAX_NAL_BYTES) begin
         size_sat = SIZE_W'(MAX_NAL_BYTES);
      end
      rem       = {1'b0, bytes_left_ff} + (SIZE_W+1)'(fill_ff);
      len_min   = (rem < (SIZE_W+1)'(lim)) ? rem : (SIZE_W+1)'(lim);
      // first fragment gives up a byte so S and E share a fragment only when it holds one byte
      frag_len  = (first_frag_ff && len_min == rem && len_min >= (SIZE_W+1)'(2))
                  ? len_min - (SIZE_W+1)'(1) : len_min;
      fill_next = (PAY_W+1)'(fill_ff) + (PAY_W+1)'(1);
      frag_ends = ((SIZE_W+1)'(fill_next) >= frag_len);
      frag_last = (frag_len == rem);
      stamp_sum = stamp_ff + stamp_step_ff;
      abandon   = (bytes_left_ff != '0) && (!fragmenting_ff || fill_ff != '0);
      seq_mid   = seq_ff + SEQ_W'(abandon);
      hdr_keeps_stamp = (header_ff[4:0] == TYPE_SPS) || (header_ff[4:0] == TYPE_PPS);
      new_keeps_stamp = (in_byte_ff[4:0] == TYPE_SPS) || (in_byte_ff[4:0] == TYPE_PPS);
      fu_indicator = (header_ff & NRI_MASK) | {3'b000, FU_A_TYPE};
      fu_header    = (header_ff & TYPE_MASK)
                   | (first_frag_ff ? S_BIT : 8'h00)
                   | (frag_last ? E_BIT : 8'h00);
   end

   // Packetizer: state update and results for one request
   always_comb begin
      seq_in         = seq_ff;
      stamp_in       = stamp_ff;
      header_in      = header_ff;
      bytes_left_in  = bytes_left_ff;
      fill_in        = fill_ff;
      fragmenting_in = fragmenting_ff;
      first_frag_in  = first_frag_ff;
      push           = '0;

      if (proc_go) begin
         if (in_first_ff) begin
            // new NAL: abandon any open one, then single packet or fragment
            seq_in        = seq_mid;
            header_in     = in_byte_ff;
            bytes_left_in = size_sat - SIZE_W'(1);
            fill_in       = '0;
            if (size_sat <= SIZE_W'(lim)) begin
               fragmenting_in = 1'b0;
               first_frag_in  = 1'b0;
               push.push_count              = 2'd1;
               push.entry[0].out_byte       = in_byte_ff;
               push.entry[0].packet_start   = 1'b1;
               push.entry[0].packet_end     = (size_sat == SIZE_W'(1));
               push.entry[0].seq_number     = seq_mid;
               push.entry[0].time_stamp     = stamp_ff;
               push.entry[0].last_of_item   = 1'b1;
               if (size_sat == SIZE_W'(1)) begin
                  seq_in = seq_mid + SEQ_W'(1);
                  if (!new_keeps_stamp) begin
                     stamp_in = stamp_sum;
                  end
               end
            end else begin
               fragmenting_in = 1'b1;
               first_frag_in  = 1'b1;
            end
         end else if (bytes_left_ff == '0) begin
            // stray byte outside a NAL
         end else if (!fragmenting_ff) begin
            // body byte of a single-packet NAL
            bytes_left_in = bytes_left_ff - SIZE_W'(1);
            push.push_count              = 2'd1;
            push.entry[0].out_byte       = in_byte_ff;
            push.entry[0].packet_start   = 1'b0;
            push.entry[0].packet_end     = (bytes_left_ff == SIZE_W'(1));
            push.entry[0].seq_number     = seq_ff;
            push.entry[0].time_stamp     = stamp_ff;
            push.entry[0].last_of_item   = 1'b1;
            if (bytes_left_ff == SIZE_W'(1)) begin
               seq_in = seq_ff + SEQ_W'(1);
               if (!hdr_keeps_stamp) begin
                  stamp_in = stamp_sum;
               end
            end
         end else begin
            // fragment data byte, preceded by FU indicator and header at fragment start
            if (fill_ff == '0) begin
               push.push_count              = 2'd3;
               push.entry[0].out_byte       = fu_indicator;
               push.entry[0].packet_start   = 1'b1;
               push.entry[0].packet_end     = 1'b0;
               push.entry[0].seq_number     = seq_ff;
               push.entry[0].time_stamp     = stamp_ff;
               push.entry[0].last_of_item   = 1'b0;
               push.entry[1].out_byte       = fu_header;
               push.entry[1].packet_start   = 1'b0;
               push.entry[1].packet_end     = 1'b0;
               push.entry[1].seq_number     = seq_ff;
               push.entry[1].time_stamp     = stamp_ff;
               push.entry[1].last_of_item   = 1'b0;
               push.entry[2].out_byte       = in_byte_ff;
               push.entry[2].packet_start   = 1'b0;
               push.entry[2].packet_end     = frag_ends;
               push.entry[2].seq_number     = seq_ff;
               push.entry[2].time_stamp     = stamp_ff;
               push.entry[2].last_of_item   = 1'b1;
            end else begin
               push.push_count              = 2'd1;
               push.entry[0].out_byte       = in_byte_ff;
               push.entry[0].packet_start   = 1'b0;
               push.entry[0].packet_end     = frag_ends;
               push.entry[0].seq_number     = seq_ff;
               push.entry[0].time_stamp     = stamp_ff;
               push.entry[0].last_of_item   = 1'b1;
            end
            fill_in       = fill_next[PAY_W-1:0];
            bytes_left_in = bytes_left_ff - SIZE_W'(1);
            if (frag_ends) begin
               seq_in        = seq_ff + SEQ_W'(1);
               fill_in       = '0;
               first_frag_in = 1'b0;
               if (bytes_left_ff == SIZE_W'(1)) begin
                  fragmenting_in = 1'b0;
                  stamp_in       = stamp_sum;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff         <= '0;
         stamp_ff       <= '0;
         header_ff      <= '0;
         bytes_left_ff  <= '0;
         fill_ff        <= '0;
         fragmenting_ff <= 1'b0;
         first_frag_ff  <= 1'b0;
      end else begin
         seq_ff         <= seq_in;
         stamp_ff       <= stamp_in;
         header_ff      <= header_in;
         bytes_left_ff  <= bytes_left_in;
         fill_ff        <= fill_in;
         fragmenting_ff <= fragmenting_in;
         first_frag_ff  <= first_frag_in;
      end
   end

   // Result queue
   h264fua_res_queue u_res_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .head_valid (rsp_tvalid),
      .head       (head),
      .head_ready (rsp_tready)
   );

   assign rsp_tdata = {7'b0, head.last_of_item, head.time_stamp, head.seq_number,
                       head.out_byte};
   assign rsp_tuser = head.packet_start;
   assign rsp_tlast = head.packet_end;

endmodule

`default_nettype wire

// ===== src/h264fua_checker.sv =====
// Port-level checks for the packetizer core, bound into every instance of the core.
`default_nettype none

module h264fua_checker
   import h264fua_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_tvalid,
   input wire logic                 req_tready,
   input wire logic [31:0]          req_tdata,
   input wire logic                 req_tuser,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [63:0]          rsp_tdata,
   input wire logic                 rsp_tuser,
   input wire logic                 rsp_tlast,
   input wire logic                 csr_valid,
   input wire logic                 csr_ready,
   input wire logic [CSR_IDX_W-1:0] csr_index,
   input wire logic [31:0]          csr_data
);

   logic rsp_fire;
   assign rsp_fire = rsp_tvalid & rsp_tready;

   // queue empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // a packet end is always the last result of its request
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |-> rsp_tdata[56])
      else $error("packet end not on last result of request");

   // a packet start that is not the request's last result is an FU indicator
   a_fu_indicator: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tuser && !rsp_tdata[56])
         |-> (rsp_tdata[4:0] == FU_A_TYPE && !rsp_tlast && !rsp_tdata[7]))
      else $error("malformed FU indicator");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed while stalled");

endmodule

bind h264_rtp_fua_packetizer_core h264fua_checker u_checker (.*);

`default_nettype wire

// ===== tb/sv/h264fua_payload_checker.sv =====
// Predicts the FU-A packetizer payload stream and checks each accepted result against it.
`timescale 1ns / 1ps

module h264fua_payload_checker
   import h264fua_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tready,
   input  wire logic [31:0]          req_tdata,   // [7:0] nal_byte, [27:8] nal_size
   input  wire logic                 req_tuser,   // nal_first
   input  wire logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic [63:0]          rsp_tdata,   // [7:0] byte, [23:8] seq, [55:24] stamp, [56] last
   input  wire logic                 rsp_tuser,   // packet_start
   input  wire logic                 rsp_tlast,   // packet_end
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data,
   output int                        fail_count,
   output int                        bytes_due
);

   // register copies
   logic [PAY_W-1:0]   payload_limit;
   logic [STAMP_W-1:0] stamp_step;

   // packetizer state
   logic [SEQ_W-1:0]   seq_next;
   logic [STAMP_W-1:0] stamp_now;
   logic [7:0]         nal_header;
   int unsigned        nal_remaining;
   int unsigned        frag_fill;
   logic               in_fragments;
   logic               at_first_frag;

   // payload bytes predicted but not yet seen on the result channel
   rsp_type            payload_due [$];
   rsp_type            step_res [3];
   int                 step_cnt;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic add_result(input logic [7:0] pay_byte, input logic pkt_start,
                             input logic pkt_end);
      rsp_type r;
      r              = '0;
      r.out_byte     = pay_byte;
      r.packet_start = pkt_start;
      r.packet_end   = pkt_end;
      r.seq_number   = seq_next;
      r.time_stamp   = stamp_now;
      step_res[step_cnt] = r;
      step_cnt++;
   endtask

   // single-packet NAL done: SPS and PPS keep the timestamp
   task automatic close_single_nal(input logic [7:0] hdr);
      seq_next++;
      if (hdr[4:0] != TYPE_SPS && hdr[4:0] != TYPE_PPS) begin
         stamp_now += stamp_step;
      end
   endtask

   task automatic packetize_byte(input logic [7:0] nal_byte, input logic nal_start,
                                 input logic [SIZE_W-1:0] size_field);
      int unsigned nal_len;
      int unsigned lim;
      int unsigned rem;
      int unsigned len;
      logic [7:0]  fu_header;
      step_cnt = 0;
      lim = (payload_limit == 0) ? 1 : payload_limit;
      if (nal_start) begin
         nal_len = (size_field == 0) ? 1 : size_field;
         if (nal_len > MAX_NAL_BYTES) begin
            nal_len = MAX_NAL_BYTES;
         end
         // new NAL cuts the old one short: an opened packet burns its number
         if (nal_remaining > 0 && (!in_fragments || frag_fill > 0)) begin
            seq_next++;
         end
         nal_header    = nal_byte;
         nal_remaining = nal_len - 1;
         frag_fill     = 0;
         if (nal_len <= lim) begin
            in_fragments  = 1'b0;
            at_first_frag = 1'b0;
            add_result(nal_byte, 1'b1, nal_len == 1);
            if (nal_len == 1) begin
               close_single_nal(nal_byte);
            end
         end else begin
            // header byte only feeds the FU indicator and FU header
            in_fragments  = 1'b1;
            at_first_frag = 1'b1;
         end
      end else if (nal_remaining == 0) begin
         // stray byte outside a NAL: dropped
      end else if (!in_fragments) begin
         nal_remaining--;
         add_result(nal_byte, 1'b0, nal_remaining == 0);
         if (nal_remaining == 0) begin
            close_single_nal(nal_header);
         end
      end else begin
         rem = nal_remaining + frag_fill;
         len = (rem < lim) ? rem : lim;
         // data exactly one limit long: shorten the first fragment so S and E split
         if (at_first_frag && len == rem && len >= 2) begin
            len--;
         end
         if (frag_fill == 0) begin
            fu_header = nal_header & TYPE_MASK;
            if (at_first_frag) begin
               fu_header |= S_BIT;
            end
            if (len == rem) begin
               fu_header |= E_BIT;
            end
            add_result((nal_header & NRI_MASK) | {3'b000, FU_A_TYPE}, 1'b1, 1'b0);
            add_result(fu_header, 1'b0, 1'b0);
         end
         frag_fill++;
         nal_remaining--;
         add_result(nal_byte, 1'b0, frag_fill >= len);
         if (frag_fill >= len) begin
            seq_next++;
            frag_fill     = 0;
            at_first_frag = 1'b0;
            if (nal_remaining == 0) begin
               in_fragments = 1'b0;
               stamp_now += stamp_step;
            end
         end
      end
      if (step_cnt > 0) begin
         step_res[step_cnt-1].last_of_item = 1'b1;
      end
      for (int i = 0; i < step_cnt; i++) begin
         payload_due.push_back(step_res[i]);
      end
   endtask

   // compare first: a result never comes from a request taken at the same edge
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         payload_limit = MAX_PAYLOAD_RST;
         stamp_step    = STAMP_STEP_RST;
         seq_next      = '0;
         stamp_now     = '0;
         nal_header    = '0;
         nal_remaining = 0;
         frag_fill     = 0;
         in_fragments  = 1'b0;
         at_first_frag = 1'b0;
         payload_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (payload_due.size() == 0) begin
               report_mismatch("unexpected result, out_byte", rsp_tdata[7:0], 32'd0);
            end else begin
               want = payload_due.pop_front();
               if (rsp_tdata[7:0] !== want.out_byte)
                  report_mismatch("out_byte", rsp_tdata[7:0], want.out_byte);
               if (rsp_tuser !== want.packet_start)
                  report_mismatch("packet_start", rsp_tuser, want.packet_start);
               if (rsp_tlast !== want.packet_end)
                  report_mismatch("packet_end", rsp_tlast, want.packet_end);
               if (rsp_tdata[23:8] !== want.seq_number)
                  report_mismatch("seq_number", rsp_tdata[23:8], want.seq_number);
               if (rsp_tdata[55:24] !== want.time_stamp)
                  report_mismatch("time_stamp", rsp_tdata[55:24], want.time_stamp);
               if (rsp_tdata[56] !== want.last_of_item)
                  report_mismatch("last_of_item", rsp_tdata[56], want.last_of_item);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_PAYLOAD: payload_limit = csr_data[PAY_W-1:0];
               CSR_STAMP_STEP:  stamp_step    = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            packetize_byte(req_tdata[7:0], req_tuser, req_tdata[27:8]);
         end
      end
      bytes_due = payload_due.size();
   end

endmodule

// ===== tb/sv/tb_h264_rtp_fua_packetizer_core.sv =====
// Stimulus and verdict for the H.264 RTP FU-A packetizer core.
`timescale 1ns / 1ps

module tb_h264_rtp_fua_packetizer_core
   import h264fua_pkg::*;
();

   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 200;
   localparam int PHASE_ITEMS   = 50;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [63:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [31:0]          csr_data   = '0;

   int                   fail_count;
   int                   bytes_due;

   // idling knobs: send gap and stall in percent of cycles, plus a hold request
   int                   send_gap_pct = 0;
   int                   stall_pct    = 0;
   int                   hold_req     = 0;
   int                   phase_items;
   int unsigned          cur_max      = 1400;
   logic                 nal_open     = 1'b0;

   h264_rtp_fua_packetizer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   h264fua_payload_checker fua_mon (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .bytes_due  (bytes_due)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: random stalls plus a long hold-off on request
   initial begin : receiver
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // one request; valid stays up when the next one follows without a gap
   task automatic offer_request(input logic [7:0] nal_byte, input logic nal_first,
                                input logic [SIZE_W-1:0] nal_size);
      @(negedge clock);
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, nal_size, nal_byte};
      req_tuser  <= nal_first;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_MAX_PAYLOAD) begin
         cur_max = value[PAY_W-1:0];
      end
   endtask

   // stop sending until every predicted byte is out, then let the pipe settle
   task automatic drain(input int settle);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (bytes_due != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // header plus data_cnt random bytes; fewer than total-1 leaves the NAL open
   task automatic send_nal(input logic [7:0] hdr, input int unsigned total,
                           input int unsigned data_cnt);
      logic [7:0]        data_byte;
      logic [SIZE_W-1:0] junk_size;
      offer_request(hdr, 1'b1, SIZE_W'(total));
      phase_items++;
      for (int i = 0; i < data_cnt; i++) begin
         data_byte = 8'($urandom_range(255));
         junk_size = SIZE_W'($urandom_range(MAX_NAL_BYTES));
         offer_request(data_byte, 1'b0, junk_size);
         phase_items++;
      end
      nal_open = (total > 1) && (data_cnt < total - 1);
   endtask

   // mostly complete NALs sized around the limit, some cut short, some noise
   task automatic random_phase(input int count);
      int unsigned lim;
      int unsigned cap;
      int unsigned pick;
      int unsigned total;
      int unsigned sent;
      logic [7:0]  hdr;
      phase_items = 0;
      lim = (cur_max == 0) ? 1 : cur_max;
      cap = (lim * 3 + 2 > 120) ? 120 : lim * 3 + 2;
      while (phase_items < count) begin
         pick = $urandom_range(99);
         hdr  = 8'($urandom_range(255));
         if ($urandom_range(4) == 0) begin
            hdr[4:0] = ($urandom_range(1) == 1) ? TYPE_SPS : TYPE_PPS;
         end
         if (pick < 5) begin
            if (!nal_open) begin
               repeat ($urandom_range(3, 1)) begin
                  offer_request(8'($urandom_range(255)), 1'b0,
                                SIZE_W'($urandom_range(MAX_NAL_BYTES)));
               end
            end
         end else if (pick < 10) begin
            send_nal(hdr, 0, 0);
         end else if (pick < 22) begin
            total = $urandom_range(MAX_NAL_BYTES);
            sent  = $urandom_range(30);
            if (total == 0) begin
               sent = 0;
            end else if (sent > total - 1) begin
               sent = total - 1;
            end
            send_nal(hdr, total, sent);
         end else if (pick < 40 && lim + 2 <= cap) begin
            total = lim - 1 + $urandom_range(3);
            send_nal(hdr, total, (total == 0) ? 0 : total - 1);
         end else begin
            total = $urandom_range(cap, 1);
            send_nal(hdr, total, total - 1);
         end
      end
   endtask

   initial begin : stimulus
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset limits: size zero, lone SPS, stray byte, short PPS
      offer_request(8'h65, 1'b1, 20'd0);
      offer_request(8'h67, 1'b1, 20'd1);
      offer_request(8'hFF, 1'b0, 20'hFFFFF);
      offer_request(8'h68, 1'b1, 20'd3);
      offer_request(8'h00, 1'b0, 20'd0);
      offer_request(8'hFF, 1'b0, 20'd0);
      // largest NAL cut short inside an open fragment, then one cut before any data
      offer_request(8'hFF, 1'b1, 20'hFFFFF);
      offer_request(8'h5A, 1'b0, 20'h12345);
      offer_request(8'hA5, 1'b0, 20'h00000);
      offer_request(8'h41, 1'b1, 20'h55555);
      nal_open = 1'b1;
      drain(SETTLE_CYCLES);

      // data exactly one limit long, then a multi-fragment NAL
      write_reg(CSR_MAX_PAYLOAD, 32'hFFFF_0002);
      write_reg(CSR_STAMP_STEP, 32'hFFFF_FFFF);
      send_nal(8'h65, 3, 2);
      send_nal(8'h7C, 7, 6);
      drain(SETTLE_CYCLES);

      // zero limit acts as one: two-byte NAL gives one fragment with S and E
      write_reg(CSR_MAX_PAYLOAD, 32'd0);
      send_nal(8'h45, 2, 1);
      send_nal(8'h06, 3, 2);
      drain(SETTLE_CYCLES);

      // limit of 16, wrapping step, no idling
      write_reg(CSR_MAX_PAYLOAD, 32'd16);
      write_reg(CSR_STAMP_STEP, 32'hFFFF_FFFF);
      random_phase(PHASE_ITEMS);
      drain(SETTLE_CYCLES);

      // largest limit, zero step, sender mostly idle, one full pause midway
      write_reg(CSR_MAX_PAYLOAD, 32'd65535);
      write_reg(CSR_STAMP_STEP, 32'd0);
      send_gap_pct = 83;
      random_phase(PHASE_ITEMS / 2);
      drain(0);
      random_phase(PHASE_ITEMS / 2);
      drain(SETTLE_CYCLES);

      // limit one, receiver mostly stalled; long hold fills the block
      write_reg(CSR_MAX_PAYLOAD, 32'd1);
      write_reg(CSR_STAMP_STEP, $urandom);
      send_gap_pct = 0;
      stall_pct    = 83;
      hold_req++;
      send_nal(8'h65, 60, 59);
      random_phase(PHASE_ITEMS);
      drain(SETTLE_CYCLES);

      // random small limit, both sides idling lightly
      write_reg(CSR_MAX_PAYLOAD, $urandom_range(48, 16));
      write_reg(CSR_STAMP_STEP, $urandom);
      send_gap_pct = 16;
      stall_pct    = 16;
      random_phase(PHASE_ITEMS);
      drain(SETTLE_CYCLES);

      // tiny random limit, no idling
      write_reg(CSR_MAX_PAYLOAD, $urandom_range(15, 2));
      write_reg(CSR_STAMP_STEP, $urandom);
      send_gap_pct = 0;
      stall_pct    = 0;
      random_phase(PHASE_ITEMS);
      drain(SETTLE_CYCLES);

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
